// File: design/csvt_pkg.sv
`default_nettype none
package csvt_pkg;

   localparam logic [7:0] QUOTE_BYTE  = 8'h22;
   localparam logic [7:0] DELIM_RESET = 8'd44;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_START   = 2'd0,
      MODE_PLAIN   = 2'd1,
      MODE_QUOTED  = 2'd2,
      MODE_PENDING = 2'd3
   } mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       field_end;
      logic       line_end;
      logic       quote_error;
      logic       last_result;
   } result_type;

   // results written into the queue for one accepted transaction
   typedef struct packed {
      logic [1:0] cnt;
      result_type slot0;
      result_type slot1;
   } push_type;

   function automatic result_type make_result(
      input logic [7:0] byte_val,
      input logic       valid,
      input logic       fend,
      input logic       lend,
      input logic       qerr,
      input logic       last
   );
      result_type r;
      r.out_byte    = valid ? byte_val : 8'd0;
      r.byte_valid  = valid;
      r.field_end   = fend;
      r.line_end    = lend;
      r.quote_error = qerr;
      r.last_result = last;
      return r;
   endfunction

endpackage
`default_nettype wire

// File: design/csvt_if.sv
`default_nettype none
interface csvt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_line;

   modport source (output valid, output char_byte, output end_line, input ready);
   modport sink   (input valid, input char_byte, input end_line, output ready);
endinterface

interface csvt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       field_end;
   logic       line_end;
   logic       quote_error;
   logic       last_result;

   modport source (output valid, output out_byte, output byte_valid, output field_end,
                   output line_end, output quote_error, output last_result, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input field_end,
                   input line_end, input quote_error, input last_result, output ready);
endinterface

interface csvt_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] wdata;

   modport source (output valid, output wdata, input ready);
   modport sink   (input valid, input wdata, output ready);
endinterface
`default_nettype wire

// File: design/csv_field_tokenizer_core.sv
`default_nettype none
// Channel   Dir   Payload                                          Handshake
// req_chan  in    char_byte[7:0], end_line                         valid/ready
// rsp_chan  out   out_byte[7:0], byte_valid, field_end, line_end,  valid/ready
//                 quote_error, last_result
// csr_chan  in    wdata[7:0] (delimiter)                           valid/ready
//
// One transaction in per cycle while the four-entry result queue has two free slots.
// Results appear at rsp_chan the cycle after acceptance at the earliest, one per cycle
// while rsp_chan is ready. A lone quote inside a quoted field yields two results,
// so throughput then follows the output port: one result per cycle.
// Reset (synchronous): field start mode, delimiter 0x2C, result queue empty.
// csr_chan is always ready.
module csv_field_tokenizer_core
   import csvt_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   csvt_req_if.sink    req_chan,
   csvt_rsp_if.source  rsp_chan,
   csvt_csr_if.sink    csr_chan
);

   push_type push;
   logic     room_ok;

   csvt_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .room_ok  (room_ok),
      .push     (push)
   );

   csvt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room_ok  (room_ok),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire

// File: design/csvt_parser.sv
`default_nettype none
module csvt_parser
   import csvt_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   csvt_req_if.sink    req_chan,
   csvt_csr_if.sink    csr_chan,
   input  wire logic   room_ok,
   output push_type    push
);

   mode_type   mode_ff, mode_in;
   logic [7:0] delim_ff, delim_in;
   logic       accept;
   logic       is_quote, is_delim;
   push_type   res;

   assign req_chan.ready = room_ok;
   assign csr_chan.ready = 1'b1;
   assign accept   = req_chan.valid && room_ok;
   assign is_quote = (req_chan.char_byte == QUOTE_BYTE);
   assign is_delim = (req_chan.char_byte == delim_ff);

   assign delim_in = (csr_chan.valid) ? csr_chan.wdata : delim_ff;

   // next mode
   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         if (req_chan.end_line) begin
            mode_in = MODE_START;
         end else begin
            unique case (mode_ff)
               MODE_START: begin
                  if (is_quote)      mode_in = MODE_QUOTED;
                  else if (is_delim) mode_in = MODE_START;
                  else               mode_in = MODE_PLAIN;
               end
               MODE_PLAIN: begin
                  if (is_delim) mode_in = MODE_START;
               end
               MODE_QUOTED: begin
                  if (is_quote) mode_in = MODE_PENDING;
               end
               MODE_PENDING: begin
                  if (is_delim) mode_in = MODE_START;
                  else          mode_in = MODE_QUOTED;
               end
               default: mode_in = MODE_START;
            endcase
         end
      end
   end

   // results
   always_comb begin
      res.cnt   = 2'd0;
      res.slot0 = make_result(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      res.slot1 = make_result(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      if (req_chan.end_line) begin
         res.cnt = 2'd1;
         unique case (mode_ff) inside
            MODE_START:   res.slot0 = make_result(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
            MODE_QUOTED:  res.slot0 = make_result(8'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
            MODE_PLAIN,
            MODE_PENDING: res.slot0 = make_result(8'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
            default:      res.slot0 = make_result(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
         endcase
      end else begin
         unique case (mode_ff)
            MODE_START: begin
               if (is_quote) begin
                  res.cnt = 2'd0;
               end else if (is_delim) begin
                  res.cnt   = 2'd1;
                  res.slot0 = make_result(8'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
               end else begin
                  res.cnt   = 2'd1;
                  res.slot0 = make_result(req_chan.char_byte, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
               end
            end
            MODE_PLAIN: begin
               res.cnt = 2'd1;
               if (is_delim) begin
                  res.slot0 = make_result(8'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
               end else begin
                  res.slot0 = make_result(req_chan.char_byte, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
               end
            end
            MODE_QUOTED: begin
               if (!is_quote) begin
                  res.cnt   = 2'd1;
                  res.slot0 = make_result(req_chan.char_byte, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
               end
            end
            MODE_PENDING: begin
               if (is_delim) begin
                  res.cnt   = 2'd1;
                  res.slot0 = make_result(8'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
               end else if (is_quote) begin
                  res.cnt   = 2'd1;
                  res.slot0 = make_result(QUOTE_BYTE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
               end else begin
                  // lone quote kept literally, then the byte
                  res.cnt   = 2'd2;
                  res.slot0 = make_result(QUOTE_BYTE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
                  res.slot1 = make_result(req_chan.char_byte, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
               end
            end
            default: res.cnt = 2'd0;
         endcase
      end
   end

   always_comb begin
      push = res;
      if (!accept) begin
         push.cnt = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_START;
         delim_ff <= DELIM_RESET;
      end else begin
         mode_ff  <= mode_in;
         delim_ff <= delim_in;
      end
   end

`ifndef SYNTHESIS
   a_two_only_pending: assert property (@(posedge clock) disable iff (reset)
      push.cnt == 2'd2 |-> mode_ff == MODE_PENDING && push.slot0.out_byte == QUOTE_BYTE)
      else $error("two results outside pending quote");
   a_eol_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.end_line |=> mode_ff == MODE_START)
      else $error("mode not back to field start after line end");
   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      push.cnt != 2'd0 |-> accept)
      else $error("results pushed without accepted transaction");
`endif

endmodule
`default_nettype wire

// File: design/csvt_queue.sv
`default_nettype none
module csvt_queue
   import csvt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          room_ok,
   csvt_rsp_if.source    rsp_chan
);

   result_type          q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic [QPTR_W-1:0]   wr_next;
   logic                pop;
   result_type          head;

   assign room_ok = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign pop     = rsp_chan.valid && rsp_chan.ready;
   assign wr_next = wr_ptr_ff + QPTR_W'(1);
   assign head    = q_ff[rd_ptr_ff];

   assign rsp_chan.valid       = (count_ff != '0);
   assign rsp_chan.out_byte    = head.out_byte;
   assign rsp_chan.byte_valid  = head.byte_valid;
   assign rsp_chan.field_end   = head.field_end;
   assign rsp_chan.line_end    = head.line_end;
   assign rsp_chan.quote_error = head.quote_error;
   assign rsp_chan.last_result = head.last_result;

   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push.cnt);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
   assign count_in  = count_ff + QCNT_W'(push.cnt) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) begin
         q_ff[wr_ptr_ff] <= push.slot0;
      end
      if (push.cnt == 2'd2) begin
         q_ff[wr_next] <= push.slot1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.cnt != 2'd0 |-> room_ok)
      else $error("push into queue without room");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      count_ff != QCNT_W'(QUEUE_DEPTH) |->
         QCNT_W'(QPTR_W'(wr_ptr_ff - rd_ptr_ff)) == count_ff)
      else $error("queue pointers disagree with fill count");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> count_ff == '0)
      else $error("queue not empty after reset");
`endif

endmodule
`default_nettype wire
